>>> hw/rtl/hvn_pkg.sv
// shared constants, types and helpers of the hashed value noise pipeline
package hvn_pkg;

	// lattice spacing
	localparam int unsigned CELL_BLOCKS  = 6000;
	localparam int unsigned CELL_SECONDS = 2400;

	// reciprocal multipliers for division by the cell spacing
	localparam int unsigned RECIP_SHIFT = 43;
	localparam logic [30:0] RECIP_BLK = 31'((64'd1 << RECIP_SHIFT) / CELL_BLOCKS);
	localparam logic [31:0] RECIP_SEC = 32'((64'd1 << RECIP_SHIFT) / CELL_SECONDS);

	// hash constants
	localparam logic [63:0] MUL_X       = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MUL_Z       = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] MUL_T       = 64'h165667B19E3779F9;
	localparam logic [63:0] MIX_A       = 64'hFF51AFD7ED558CCD;
	localparam logic [63:0] MIX_B       = 64'hC4CEB9FE1A85EC53;
	localparam logic [63:0] LATTICE_KEY = 64'h00000000000C10D5;

	localparam int unsigned NCORNER = 8;

	typedef logic [15:0] val_t;
	typedef logic [16:0] weight_t;
	typedef logic [63:0] hash_t;

	// lattice corner coordinates of one item
	typedef struct packed {
		logic [31:0] cx;
		logic [31:0] cz;
		logic [31:0] ct;
	} lattice_t;

	// position inside the cell
	typedef struct packed {
		logic [12:0] rx;
		logic [12:0] rz;
		logic [27:0] rt;
	} remain_t;

	// full 32 by 32 product
	function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
		return {32'd0, a} * {32'd0, b};
	endfunction

endpackage

>>> hw/rtl/hvn_cell.sv
// floor division of position and time by the cell spacing, three stages
module hvn_cell import hvn_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_z,
	input  logic [47:0]        time_q16,
	output lattice_t           lat,
	output remain_t            rem
);

	logic signed [31:0] pos [2];
	logic [30:0] n_c [2];
	logic        neg_s1 [2];
	logic [30:0] n_s1 [2];
	logic [61:0] prod_s1 [2];
	logic [31:0] nt_s1;
	logic [15:0] tlo_s1;
	logic [63:0] prodt_s1;

	logic [18:0] qe_c [2];
	logic [31:0] rf_c [2];
	logic [20:0] qt_c;
	logic [31:0] rtf_c;
	logic        neg_s2 [2];
	logic [18:0] qe_s2 [2];
	logic [13:0] r_s2 [2];
	logic [20:0] qt_s2;
	logic [12:0] rt_s2;
	logic [15:0] tlo_s2;

	logic [18:0] q_c [2];
	logic [12:0] rr_c [2];
	logic [31:0] cell_c [2];
	logic [12:0] rem_c [2];
	logic [20:0] qtc_c;
	logic [11:0] rtc_c;
	lattice_t    cell_s3;
	remain_t     rem_s3;

	assign pos[0] = pos_x;
	assign pos[1] = pos_z;

	// negative values divide their complement
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			n_c[l] = pos[l][31] ? ~pos[l][30:0] : pos[l][30:0];
		end
	end

	// quotient estimate and remainder
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			qe_c[l] = prod_s1[l][61:43];
			rf_c[l] = {1'b0, n_s1[l]} - {13'd0, qe_c[l]} * 32'(CELL_BLOCKS);
		end
		qt_c  = prodt_s1[63:43];
		rtf_c = nt_s1 - {11'd0, qt_c} * 32'(CELL_SECONDS);
	end

	// one correction step, then undo the complement
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (r_s2[l] >= 14'(CELL_BLOCKS)) begin
				q_c[l]  = qe_s2[l] + 19'd1;
				rr_c[l] = 13'(r_s2[l] - 14'(CELL_BLOCKS));
			end else begin
				q_c[l]  = qe_s2[l];
				rr_c[l] = r_s2[l][12:0];
			end
			if (neg_s2[l]) begin
				cell_c[l] = ~{13'd0, q_c[l]};
				rem_c[l]  = 13'(CELL_BLOCKS - 1) - rr_c[l];
			end else begin
				cell_c[l] = {13'd0, q_c[l]};
				rem_c[l]  = rr_c[l];
			end
		end
		if (rt_s2 >= 13'(CELL_SECONDS)) begin
			qtc_c = qt_s2 + 21'd1;
			rtc_c = 12'(rt_s2 - 13'(CELL_SECONDS));
		end else begin
			qtc_c = qt_s2;
			rtc_c = rt_s2[11:0];
		end
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				neg_s1[l]  <= pos[l][31];
				n_s1[l]    <= n_c[l];
				prod_s1[l] <= {31'd0, n_c[l]} * {31'd0, RECIP_BLK};
				neg_s2[l]  <= neg_s1[l];
				qe_s2[l]   <= qe_c[l];
				r_s2[l]    <= rf_c[l][13:0];
			end
			nt_s1    <= time_q16[47:16];
			tlo_s1   <= time_q16[15:0];
			prodt_s1 <= mul32(time_q16[47:16], RECIP_SEC);
			qt_s2    <= qt_c;
			rt_s2    <= rtf_c[12:0];
			tlo_s2   <= tlo_s1;
			cell_s3.cx <= cell_c[0];
			cell_s3.cz <= cell_c[1];
			cell_s3.ct <= {11'd0, qtc_c};
			rem_s3.rx  <= rem_c[0];
			rem_s3.rz  <= rem_c[1];
			rem_s3.rt  <= {rtc_c, tlo_s2};
		end
	end

	assign lat = cell_s3;
	assign rem = rem_s3;

endmodule

>>> hw/rtl/hvn_frac.sv
// rounded Q0.16 cell fractions for x, z and time, three stages
module hvn_frac import hvn_pkg::*; (
	input  logic    clk,
	input  logic    en,
	input  remain_t rem,
	output weight_t fx,
	output weight_t fz,
	output weight_t ft
);

	localparam logic [13:0] DIV [3] = '{14'(CELL_BLOCKS), 14'(CELL_BLOCKS), 14'(CELL_SECONDS)};
	localparam logic [31:0] RCP [3] = '{{1'b0, RECIP_BLK}, {1'b0, RECIP_BLK}, RECIP_SEC};

	logic [28:0] num_c [3];
	logic [28:0] num_s1 [3];
	logic [60:0] prod_s1 [3];
	logic [16:0] fe_c [3];
	logic [31:0] rf_c [3];
	logic [16:0] fe_s2 [3];
	logic [13:0] r_s2 [3];
	weight_t     f_s3 [3];

	// numerators with half the divisor added for rounding
	always_comb begin
		num_c[0] = {rem.rx, 16'd0} + 29'(CELL_BLOCKS / 2);
		num_c[1] = {rem.rz, 16'd0} + 29'(CELL_BLOCKS / 2);
		num_c[2] = {1'b0, rem.rt} + 29'(CELL_SECONDS / 2);
	end

	// quotient estimate and remainder
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			fe_c[l] = prod_s1[l][59:43];
			rf_c[l] = {3'd0, num_s1[l]} - {15'd0, fe_c[l]} * {18'd0, DIV[l]};
		end
	end

	// stage registers with the final correction step
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				num_s1[l]  <= num_c[l];
				prod_s1[l] <= 61'(mul32({3'd0, num_c[l]}, RCP[l]));
				fe_s2[l]   <= fe_c[l];
				r_s2[l]    <= rf_c[l][13:0];
				f_s3[l]    <= (r_s2[l] >= DIV[l]) ? fe_s2[l] + 17'd1 : fe_s2[l];
			end
		end
	end

	assign fx = f_s3[0];
	assign fz = f_s3[1];
	assign ft = f_s3[2];

endmodule

>>> hw/rtl/hvn_smooth.sv
// smoothstep weight of one Q0.16 fraction, three stages
module hvn_smooth import hvn_pkg::*; (
	input  logic    clk,
	input  logic    en,
	input  weight_t f,
	output weight_t w
);

	logic [33:0] ff_s1;
	weight_t     f_s1;
	logic [16:0] q_c;
	logic [17:0] d_c;
	logic [34:0] prod_s2;
	weight_t     w_s3;

	// square rounded to Q0.16, times three minus twice the fraction
	always_comb begin
		q_c = 17'((ff_s1 + 34'd32768) >> 16);
		d_c = 18'd196608 - {f_s1, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ff_s1   <= {17'd0, f} * {17'd0, f};
			f_s1    <= f;
			prod_s2 <= {18'd0, q_c} * {17'd0, d_c};
			w_s3    <= 17'((prod_s2 + 35'd32768) >> 16);
		end
	end

	assign w = w_s3;

endmodule

>>> hw/rtl/hvn_lattice.sv
// keyed initial hash of the eight cell corners, two stages
module hvn_lattice import hvn_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  lattice_t lat,
	input  hash_t    key,
	output hash_t    h0 [NCORNER]
);

	localparam hash_t MULS [6] = '{MUL_X, MUL_X, MUL_Z, MUL_Z, MUL_T, MUL_T};

	logic [31:0] v_c [6];
	logic [63:0] lo_s1 [6];
	logic [31:0] hi_s1 [6];
	hash_t       p_c [6];
	hash_t       h0_s2 [NCORNER];

	// low and high coordinate of each axis
	always_comb begin
		v_c[0] = lat.cx;
		v_c[1] = lat.cx + 32'd1;
		v_c[2] = lat.cz;
		v_c[3] = lat.cz + 32'd1;
		v_c[4] = lat.ct;
		v_c[5] = lat.ct + 32'd1;
	end

	// products mod 2^64 from two partial products
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			p_c[i] = lo_s1[i] + {hi_s1[i], 32'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				lo_s1[i] <= mul32(v_c[i], MULS[i][31:0]);
				hi_s1[i] <= 32'(mul32(v_c[i], MULS[i][63:32]));
			end
			// corner bits are {dt, dz, dx}
			for (int c = 0; c < NCORNER; c++) begin
				h0_s2[c] <= p_c[c % 2] ^ p_c[2 + (c / 2) % 2] ^ p_c[4 + c / 4] ^ key;
			end
		end
	end

	assign h0 = h0_s2;

endmodule

>>> hw/rtl/hvn_mix.sv
// multiply-xorshift finalizer of one corner hash, three stages
module hvn_mix import hvn_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  hash_t h,
	output val_t  value
);

	hash_t       a_c;
	hash_t       m_c;
	hash_t       b_c;
	hash_t       m2_c;
	logic [63:0] pa0_s1;
	logic [31:0] pa1_s1;
	logic [31:0] pa2_s1;
	logic [63:0] pb0_s2;
	logic [31:0] pb1_s2;
	logic [31:0] pb2_s2;
	val_t        value_s3;

	// shift-xor steps around the two wide multiplies
	always_comb begin
		a_c  = h ^ (h >> 33);
		m_c  = pa0_s1 + {pa1_s1 + pa2_s1, 32'd0};
		b_c  = m_c ^ (m_c >> 29);
		m2_c = pb0_s2 + {pb1_s2 + pb2_s2, 32'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa0_s1   <= mul32(a_c[31:0], MIX_A[31:0]);
			pa1_s1   <= 32'(mul32(a_c[31:0], MIX_A[63:32]));
			pa2_s1   <= 32'(mul32(a_c[63:32], MIX_A[31:0]));
			pb0_s2   <= mul32(b_c[31:0], MIX_B[31:0]);
			pb1_s2   <= 32'(mul32(b_c[31:0], MIX_B[63:32]));
			pb2_s2   <= 32'(mul32(b_c[63:32], MIX_B[31:0]));
			// last xor-shift folded into the picked bits
			value_s3 <= m2_c[23:8] ^ m2_c[55:40];
		end
	end

	assign value = value_s3;

endmodule

>>> hw/rtl/hvn_lerp.sv
// rounded linear blend of two Q0.16 values, one stage
module hvn_lerp import hvn_pkg::*; (
	input  logic    clk,
	input  logic    en,
	input  val_t    a,
	input  val_t    b,
	input  weight_t w,
	output val_t    y
);

	logic [16:0] wn_c;
	logic [33:0] sum_c;
	val_t        y_s1;

	always_comb begin
		wn_c  = 17'd65536 - w;
		sum_c = {17'd0, a} * {17'd0, wn_c} + {17'd0, b} * {17'd0, w} + 34'd32768;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1 <= sum_c[31:16];
		end
	end

	assign y = y_s1;

endmodule

>>> hw/rtl/hashed_value_noise_3d.sv
// top level of the hashed value noise pipeline
//
// Takes one (pos_x, pos_z, time_q16) request per cycle and returns its Q0.16
// noise value, one result per cycle in request order, whenever the pipeline
// moves. The pipeline has three stages of floor division, three of cell
// fractions, three of smoothstep weights that run beside the corner hash
// finalizers, and three blend stages along x, z and time. When a result is
// stalled the whole pipeline holds and item_stall rises in the same cycle;
// nothing is lost or repeated. noise_seed is written with noise_seed_we and
// should be changed only while no request is in flight.
module hashed_value_noise_3d import hvn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               noise_seed_we,
	input  logic [63:0]        noise_seed,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_z,
	input  logic [47:0]        time_q16,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [15:0]        noise_value
);

	localparam int unsigned DEPTH = 12;

	logic             adv;
	logic [DEPTH:1]   stage_vld_q;
	hash_t            seed_q;
	lattice_t         lat;
	remain_t          rem;
	weight_t          fx;
	weight_t          fz;
	weight_t          ft;
	weight_t          wx;
	weight_t          wz;
	weight_t          wt;
	hash_t            h0 [NCORNER];
	val_t             corner [NCORNER];
	val_t             corner_s9 [NCORNER];
	weight_t          wz_s10;
	weight_t          wt_s10;
	weight_t          wt_s11;
	val_t             xl [4];
	val_t             zl [2];
	val_t             tl;

	// pipeline moves unless a finished result is held
	assign adv        = !(stage_vld_q[DEPTH] && result_stall);
	assign item_stall = !adv;

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (noise_seed_we) begin
			seed_q <= noise_seed;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (adv) begin
			stage_vld_q <= {stage_vld_q[DEPTH-1:1], item_valid};
		end
	end

	// cell and remainders, stages 1 to 3
	hvn_cell u_cell (
		.clk      (clk),
		.en       (adv),
		.pos_x    (pos_x),
		.pos_z    (pos_z),
		.time_q16 (time_q16),
		.lat      (lat),
		.rem      (rem)
	);

	// fractions, stages 4 to 6
	hvn_frac u_frac (
		.clk (clk),
		.en  (adv),
		.rem (rem),
		.fx  (fx),
		.fz  (fz),
		.ft  (ft)
	);

	// weights, stages 7 to 9
	hvn_smooth u_smooth_x (.clk(clk), .en(adv), .f(fx), .w(wx));
	hvn_smooth u_smooth_z (.clk(clk), .en(adv), .f(fz), .w(wz));
	hvn_smooth u_smooth_t (.clk(clk), .en(adv), .f(ft), .w(wt));

	// corner hashes, stages 4 to 8
	hvn_lattice u_lattice (
		.clk  (clk),
		.en   (adv),
		.lat  (lat),
		.key  (seed_q ^ LATTICE_KEY),
		.h0   (h0)
	);

	for (genvar c = 0; c < NCORNER; c++) begin : g_mix
		hvn_mix u_mix (
			.clk   (clk),
			.en    (adv),
			.h     (h0[c]),
			.value (corner[c])
		);
	end

	// line corner values and later weights up with their blend stage
	always_ff @(posedge clk) begin
		if (adv) begin
			corner_s9 <= corner;
			wz_s10    <= wz;
			wt_s10    <= wt;
			wt_s11    <= wt_s10;
		end
	end

	// blend along x, stage 10
	for (genvar k = 0; k < 4; k++) begin : g_lerp_x
		hvn_lerp u_lerp (
			.clk (clk),
			.en  (adv),
			.a   (corner_s9[2*k]),
			.b   (corner_s9[2*k+1]),
			.w   (wx),
			.y   (xl[k])
		);
	end

	// blend along z, stage 11
	for (genvar k = 0; k < 2; k++) begin : g_lerp_z
		hvn_lerp u_lerp (
			.clk (clk),
			.en  (adv),
			.a   (xl[2*k]),
			.b   (xl[2*k+1]),
			.w   (wz_s10),
			.y   (zl[k])
		);
	end

	// blend along time, stage 12 is the output register
	hvn_lerp u_lerp_t (
		.clk (clk),
		.en  (adv),
		.a   (zl[0]),
		.b   (zl[1]),
		.w   (wt_s11),
		.y   (tl)
	);

	assign result_valid = stage_vld_q[DEPTH];
	assign noise_value  = tl;

	// a held result freezes every stage
	a_hold_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		stage_vld_q[DEPTH] && result_stall |=> $stable(stage_vld_q))
		else $error("pipeline moved while result held");

	// an accepted request enters the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> stage_vld_q[1])
		else $error("accepted request lost at entry");

	// the last inner stage reaches the output when the pipeline moves
	a_reach_output: assert property (@(posedge clk) disable iff (!arst_n)
		stage_vld_q[DEPTH-1] && !item_stall |=> result_valid)
		else $error("request lost before output");

endmodule

>>> dv/hashed_value_noise_3d_tb.sv
// testbench of the hashed value noise pipeline: directed table, random requests, predictor checks
`timescale 1ns / 100ps

module hashed_value_noise_3d_tb;
	import hvn_pkg::*;

	localparam longint unsigned TIME_SPAN = 64'd2400 << 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 30;

	logic               clk;
	logic               arst_n;
	logic               noise_seed_we;
	logic [63:0]        noise_seed;
	logic               item_valid;
	logic               item_stall;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_z;
	logic [47:0]        time_q16;
	logic               result_valid;
	logic               result_stall;
	logic [15:0]        noise_value;

	// one directed request
	typedef struct {
		logic [31:0] x;
		logic [31:0] z;
		logic [47:0] t;
	} noise_req_t;

	logic [63:0]  model_seed;
	logic [15:0]  pending_noise[$];
	int           error_count;
	int           idle_cycles;
	int           send_idle_pct;
	int           recv_stall_pct;
	bit           hold_req;
	bit           item_taken;
	bit           result_taken;
	logic [31:0]  seen_x;
	logic [31:0]  seen_z;
	logic [47:0]  seen_t;
	logic [15:0]  seen_noise;

	hashed_value_noise_3d uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.noise_seed_we(noise_seed_we),
		.noise_seed   (noise_seed),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.pos_x        (pos_x),
		.pos_z        (pos_z),
		.time_q16     (time_q16),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.noise_value  (noise_value)
	);

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// smoothstep weight, 65536 is one
	function automatic logic [63:0] smooth_of(input logic [63:0] f);
		logic [63:0] q;
		q = (f * f + 64'd32768) >> 16;
		return (q * (64'd196608 - 64'd2 * f) + 64'd32768) >> 16;
	endfunction

	// rounded lerp
	function automatic logic [63:0] lerp_of(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] w);
		return (a * (64'd65536 - w) + b * w + 64'd32768) >> 16;
	endfunction

	// hashed corner value in q0.16
	function automatic logic [63:0] corner_of(input logic [31:0] cx, input logic [31:0] cz,
			input logic [63:0] ct, input logic [63:0] seed);
		logic [63:0] h;
		h = {32'd0, cx} * 64'h9E3779B97F4A7C15;
		h ^= {32'd0, cz} * 64'hC2B2AE3D27D4EB4F;
		h ^= ct * 64'h165667B19E3779F9;
		h ^= seed ^ 64'h00000000000C10D5;
		h ^= h >> 33;
		h *= 64'hFF51AFD7ED558CCD;
		h ^= h >> 29;
		h *= 64'hC4CEB9FE1A85EC53;
		h ^= h >> 32;
		return {48'd0, h[23:8]};
	endfunction

	// floor division by the cell width, remainder never negative
	function automatic void split_cell(input logic [31:0] p, output longint c, output longint r);
		longint sp;
		sp = longint'(signed'(p));
		c = sp / 6000;
		r = sp - c * 6000;
		if (r < 0) begin
			c -= 1;
			r += 6000;
		end
	endfunction

	// full noise value of one request
	function automatic logic [15:0] noise_of(input logic [63:0] seed, input logic [31:0] x,
			input logic [31:0] z, input logic [47:0] t);
		longint      x0, rx, z0, rz;
		logic [63:0] t0, rt, wx, wz, wt, near_row, far_row;
		logic [63:0] layer[2];
		logic [31:0] ax, bx, az, bz;
		logic [63:0] res;
		split_cell(x, x0, rx);
		split_cell(z, z0, rz);
		t0 = {16'd0, t} / TIME_SPAN;
		rt = {16'd0, t} - t0 * TIME_SPAN;
		wx = smooth_of((64'(rx) * 64'd65536 + 64'd3000) / 64'd6000);
		wz = smooth_of((64'(rz) * 64'd65536 + 64'd3000) / 64'd6000);
		wt = smooth_of((rt + 64'd1200) / 64'd2400);
		ax = 32'(x0);
		bx = ax + 32'd1;
		az = 32'(z0);
		bz = az + 32'd1;
		for (int dt = 0; dt < 2; dt++) begin
			near_row = lerp_of(corner_of(ax, az, t0 + dt, seed), corner_of(bx, az, t0 + dt, seed), wx);
			far_row = lerp_of(corner_of(ax, bz, t0 + dt, seed), corner_of(bx, bz, t0 + dt, seed), wx);
			layer[dt] = lerp_of(near_row, far_row, wz);
		end
		res = lerp_of(layer[0], layer[1], wt);
		return res[15:0];
	endfunction

	// sample both channels just before the rising edge
	always begin
		@(negedge clk);
		#9;
		item_taken = arst_n && item_valid && !item_stall;
		result_taken = arst_n && result_valid && !result_stall;
		seen_x = pos_x;
		seen_z = pos_z;
		seen_t = time_q16;
		seen_noise = noise_value;
	end

	// predict accepted requests, check accepted results
	always @(posedge clk) begin
		if (item_taken)
			pending_noise.push_back(noise_of(model_seed, seen_x, seen_z, seen_t));
		if (result_taken) begin
			if (pending_noise.size() == 0) begin
				$display("%0t: unexpected result noise_value=%h", $realtime, seen_noise);
				error_count++;
			end else begin
				if (pending_noise[0] !== seen_noise) begin
					$display("%0t: noise_value mismatch expected=%h actual=%h",
						$realtime, pending_noise[0], seen_noise);
					error_count++;
				end
				void'(pending_noise.pop_front());
			end
		end
		if (item_taken || result_taken)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stall, with one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			result_stall <= 1'b1;
			for (int i = 0; i < HOLD_CYCLES; i++)
				@(negedge clk);
			hold_req = 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// offer one request and wait until it is taken
	task automatic send_req(input logic [31:0] x, input logic [31:0] z, input logic [47:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		pos_x <= x;
		pos_z <= z;
		time_q16 <= t;
		do
			@(negedge clk);
		while (!item_taken);
	endtask

	// wait for the pipeline to drain, then write the seed
	task automatic write_seed(input logic [63:0] seed);
		item_valid <= 1'b0;
		@(negedge clk);
		while (pending_noise.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		noise_seed_we <= 1'b1;
		noise_seed <= seed;
		model_seed = seed;
		@(negedge clk);
		noise_seed_we <= 1'b0;
	endtask

	// random coordinate, often close to a cell edge
	function automatic logic [31:0] rand_pos();
		logic [31:0] p;
		case ($urandom_range(3))
			0: p = $urandom;
			1: p = 32'(($urandom_range(700000) - 350000) * 6000 + $urandom_range(4) - 2);
			2: p = 32'($urandom_range(40000) - 20000);
			default: p = {$urandom_range(1) ? 1'b1 : 1'b0, {31{$urandom_range(1) ? 1'b1 : 1'b0}}}
				^ 32'($urandom_range(7));
		endcase
		return p;
	endfunction

	// random time stamp, often close to a cell edge
	function automatic logic [47:0] rand_time();
		logic [63:0] t;
		case ($urandom_range(2))
			0: t = {$urandom, $urandom};
			1: t = 64'($urandom_range(1780)) * TIME_SPAN + 64'($urandom_range(2400)) - 64'd1200;
			default: t = 64'($urandom);
		endcase
		return t[47:0];
	endfunction

	noise_req_t directed[] = '{
		'{32'h00000000, 32'h00000000, 48'h000000000000},
		'{32'h80000000, 32'h80000000, 48'hFFFFFFFFFFFF},
		'{32'h7FFFFFFF, 32'h7FFFFFFF, 48'h000000000000},
		'{32'h80000000, 32'h7FFFFFFF, 48'h0000FFFFFFFF},
		'{32'hFFFFFFFF, 32'hFFFFFFFF, 48'h000000000001},
		'{32'd5999, 32'd6000, 48'h000000000000},
		'{-32'sd6000, -32'sd6001, 48'h000000000000},
		'{32'd3000, 32'd2999, 48'd78643200},
		'{32'd1, -32'sd1, 48'd157286399},
		'{32'd0, 32'd0, 48'd157285200},
		'{32'd0, 32'd0, 48'd157285199},
		'{32'd12345, -32'sd54321, 48'd157286400},
		'{32'h55555555, 32'hAAAAAAAA, 48'hAAAAAAAAAAAA},
		'{32'hAAAAAAAA, 32'h55555555, 48'h555555555555},
		'{-32'sd2147478000, 32'd2147478000, 48'd281474976000000},
		'{32'd6000, 32'd12000, 48'd314572800}
	};

	logic [63:0] phase_seeds[5];

	// stimulus
	initial begin
		arst_n = 1'b0;
		noise_seed_we = 1'b0;
		noise_seed = '0;
		item_valid = 1'b0;
		pos_x = '0;
		pos_z = '0;
		time_q16 = '0;
		result_stall = 1'b0;
		model_seed = '0;
		error_count = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		item_taken = 1'b0;
		result_taken = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table with reset seed
		foreach (directed[i])
			send_req(directed[i].x, directed[i].z, directed[i].t);

		phase_seeds[0] = 64'hFFFFFFFFFFFFFFFF;
		phase_seeds[1] = 64'h00000000000C10D5;
		phase_seeds[2] = {$urandom, $urandom};
		phase_seeds[3] = 64'h0000000000000000;
		phase_seeds[4] = {$urandom, $urandom};

		// random phases, each under its own seed and through every idling mix
		for (int ph = 0; ph < 5; ph++) begin
			write_seed(phase_seeds[ph]);
			for (int mode = 0; mode < 4; mode++) begin
				send_idle_pct = (mode == 1 || mode == 3) ? (mode == 1 ? 56 : 37) : 0;
				recv_stall_pct = (mode == 2 || mode == 3) ? (mode == 2 ? 56 : 37) : 0;
				if (ph == 2 && mode == 0)
					hold_req = 1'b1;
				for (int k = 0; k < 52; k++)
					send_req(rand_pos(), rand_pos(), rand_time());
			end
		end
		item_valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;

		// drain
		while (pending_noise.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
